[rtl/core/scfd_pkg.sv]
`timescale 1ns / 1ps

package scfd_pkg;

  localparam int DATA_W    = 8;
  localparam int REC_BYTES = 6;
  localparam int REC_W     = REC_BYTES * DATA_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;

  localparam logic [DATA_W-1:0] HEADER_RESET = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_transfer;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]         servo_id;
    logic signed [15:0] target_position;
    logic [15:0]        move_speed;
    logic [7:0]         move_accel;
    logic               last_record;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_FETCH,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic beat;
    logic rd_en;
    logic rd_clr;
    logic rd_inc;
  } cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic last_rec;
  } status_t;

endpackage

[rtl/core/scfd_ram.sv]
`timescale 1ns / 1ps

module scfd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 12,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/scfd_ctrl.sv]
`timescale 1ns / 1ps

module scfd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  scfd_pkg::status_t st,
  output scfd_pkg::cmd_t  cmd
);

  import scfd_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   beat;

  assign beat = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RECV: begin
        if (beat && st.frame_ok) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          state_nxt = st.last_rec ? ST_RECV : ST_FETCH;
        end
      end
      default: state_nxt = ST_RECV;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    cmd.beat   = beat;
    unique case (state_r)
      ST_RECV: begin
        in_ready   = 1'b1;
        cmd.rd_clr = 1'b1;
      end
      ST_FETCH: begin
        cmd.rd_en = 1'b1;
      end
      ST_SHOW: begin
        out_valid  = 1'b1;
        cmd.rd_inc = out_ready && !st.last_rec;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/core/scfd_dp.sv]
`timescale 1ns / 1ps

module scfd_dp #(
  parameter int SERVOS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [scfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scfd_pkg::DATA_W-1:0]      cfg_wdata,
  input  scfd_pkg::in_beat_t               in_data,
  output scfd_pkg::out_beat_t              out_data,
  input  scfd_pkg::cmd_t                   cmd,
  output scfd_pkg::status_t                st
);

  import scfd_pkg::*;

  localparam int StoreLen = REC_BYTES * SERVOS;
  localparam int FrameLen = StoreLen + 3;
  localparam int CntW     = $clog2(FrameLen + 1);
  localparam int RecW     = (SERVOS > 1) ? $clog2(SERVOS) : 1;
  localparam int AsmW     = REC_W - DATA_W;

  logic [DATA_W-1:0] hdr_first_r;
  logic [DATA_W-1:0] hdr_second_r;
  logic [CntW-1:0]   cnt_r;
  logic [CntW-1:0]   cnt_nxt;
  logic [DATA_W-1:0] sum_r;
  logic [DATA_W-1:0] sum_nxt;
  logic              hdr_good_r;
  logic              hdr_good_nxt;
  logic [2:0]        slot_r;
  logic [2:0]        slot_nxt;
  logic [RecW-1:0]   wr_rec_r;
  logic [RecW-1:0]   wr_rec_nxt;
  logic [RecW-1:0]   rd_rec_r;
  logic [RecW-1:0]   rd_rec_nxt;
  logic [AsmW-1:0]   asm_r;
  logic [AsmW-1:0]   asm_nxt;
  logic [DATA_W-1:0] b;
  logic              in_store;
  logic              wr_en;
  logic [REC_W-1:0]  rd_word;

  assign b        = in_data.data_byte;
  assign in_store = (cnt_r >= CntW'(2)) && (cnt_r < CntW'(StoreLen + 2));
  assign wr_en    = cmd.beat && !in_data.end_of_transfer && in_store
                    && (slot_r == 3'(REC_BYTES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= HEADER_RESET;
      hdr_second_r <= HEADER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  hdr_first_r  <= cfg_wdata;
        CFG_HEADER_SECOND: hdr_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    hdr_good_nxt = hdr_good_r;
    slot_nxt     = slot_r;
    wr_rec_nxt   = wr_rec_r;
    asm_nxt      = asm_r;
    if (cmd.beat) begin
      if (in_data.end_of_transfer) begin
        cnt_nxt      = '0;
        sum_nxt      = '0;
        hdr_good_nxt = 1'b1;
        slot_nxt     = '0;
        wr_rec_nxt   = '0;
      end else begin
        if (cnt_r == CntW'(0) && b != hdr_first_r) begin
          hdr_good_nxt = 1'b0;
        end
        if (cnt_r == CntW'(1) && b != hdr_second_r) begin
          hdr_good_nxt = 1'b0;
        end
        if (in_store) begin
          asm_nxt = {asm_r[AsmW-DATA_W-1:0], b};
          if (slot_r == 3'(REC_BYTES - 1)) begin
            slot_nxt   = '0;
            wr_rec_nxt = wr_rec_r + RecW'(1);
          end else begin
            slot_nxt = slot_r + 3'd1;
          end
        end
        sum_nxt = sum_r + b;
        if (cnt_r < CntW'(FrameLen)) begin
          cnt_nxt = cnt_r + CntW'(1);
        end
      end
    end
  end

  always_comb begin
    rd_rec_nxt = rd_rec_r;
    if (cmd.rd_clr) begin
      rd_rec_nxt = '0;
    end else if (cmd.rd_inc) begin
      rd_rec_nxt = rd_rec_r + RecW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      sum_r      <= '0;
      hdr_good_r <= 1'b1;
      slot_r     <= '0;
      wr_rec_r   <= '0;
      rd_rec_r   <= '0;
    end else begin
      cnt_r      <= cnt_nxt;
      sum_r      <= sum_nxt;
      hdr_good_r <= hdr_good_nxt;
      slot_r     <= slot_nxt;
      wr_rec_r   <= wr_rec_nxt;
      rd_rec_r   <= rd_rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
  end

  scfd_ram #(
    .WIDTH(REC_W),
    .DEPTH(SERVOS),
    .ADDR_W(RecW)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_rec_r),
    .wdata({asm_r, b}),
    .re   (cmd.rd_en),
    .raddr(rd_rec_r),
    .rdata(rd_word)
  );

  assign st.frame_ok = in_data.end_of_transfer && (cnt_r == CntW'(FrameLen - 1))
                       && hdr_good_r && (sum_r == b);
  assign st.last_rec = (rd_rec_r == RecW'(SERVOS - 1));

  assign out_data.servo_id        = rd_word[47:40];
  assign out_data.target_position = {rd_word[31:24], rd_word[39:32]};
  assign out_data.move_speed      = {rd_word[15:8], rd_word[23:16]};
  assign out_data.move_accel      = rd_word[7:0];
  assign out_data.last_record     = st.last_rec;

endmodule

[rtl/core/servo_command_frame_deframer.sv]
`timescale 1ns / 1ps

// Servo command frame deframer. Takes one byte per cycle while receiving; a frame
// of 6*SERVOS+3 bytes passes when its two header bytes match the header
// registers and its last byte equals the 8-bit sum of the bytes before it.
// Record bytes are packed six at a time into a SERVOS-deep record memory as they
// arrive. After a passing frame the block stops taking bytes and plays out
// SERVOS records, each by a memory read and then presentation; readout
// stretches with any output stall. Failing frames give no records, and the
// block keeps taking bytes.
module servo_command_frame_deframer #(
  parameter int SERVOS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [scfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scfd_pkg::DATA_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  scfd_pkg::in_beat_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output scfd_pkg::out_beat_t            out_data
);

  import scfd_pkg::*;

  cmd_t    cmd;
  status_t st;

  scfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .st       (st),
    .cmd      (cmd)
  );

  scfd_dp #(
    .SERVOS(SERVOS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .st       (st)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken during readout");

  a_frame_starts_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && st.frame_ok) |=> (!in_ready && !out_valid))
    else $error("passing frame did not start readout");

  a_last_ends_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_record) |=> (in_ready && !out_valid))
    else $error("readout did not end after last record");

  a_rec_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_record) |=> (!out_valid && !in_ready)
    ##1 out_valid)
    else $error("next record not presented");

endmodule
